// File: rtl/ntd_pkg.sv
// ----------------------------------------------------------------------------
// ntd_pkg
// Shared types and constants of the NTC thermal current derating block.
// ----------------------------------------------------------------------------
package ntd_pkg;

	localparam int unsigned TABLE_POINTS = 7;
	localparam int unsigned SEGS = TABLE_POINTS - 1;
	localparam int unsigned SEG_W = $clog2(SEGS);

	localparam logic [11:0] NTC_MV [TABLE_POINTS] = '{
		12'd2950, 12'd2480, 12'd1840, 12'd1230, 12'd780, 12'd490, 12'd320
	};
	localparam logic [13:0] NTC_CENTI [TABLE_POINTS] = '{
		14'd0, 14'd2500, 14'd5000, 14'd7500, 14'd10000, 14'd12500, 14'd15000
	};
	localparam logic [9:0] SEG_DIV [SEGS] = '{
		10'd470, 10'd640, 10'd610, 10'd450, 10'd290, 10'd170
	};
	localparam logic [63:0] RECIP_ONE = 64'h1_0000_0000;
	localparam logic [24:0] SEG_RECIP [SEGS] = '{
		25'(RECIP_ONE / 64'd470), 25'(RECIP_ONE / 64'd640),
		25'(RECIP_ONE / 64'd610), 25'(RECIP_ONE / 64'd450),
		25'(RECIP_ONE / 64'd290), 25'(RECIP_ONE / 64'd170)
	};
	localparam logic [20:0] SEG_SPAN = 21'd2500;
	localparam logic [15:0] SCALE_ONE = 16'h8000;

	localparam logic [1:0] CFG_BOARD_FAULT = 2'd0;
	localparam logic [1:0] CFG_STATOR_FAULT = 2'd1;
	localparam logic [1:0] CFG_MARGIN = 2'd2;

	typedef enum logic [1:0] {
		CLS_ONE,
		CLS_ZERO,
		CLS_DIV
	} cls_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic [14:0] board_fault;
		logic [14:0] stator_fault;
		logic [14:0] margin;
	} cfg_t;

	typedef struct packed {
		cls_t        cls;
		logic [14:0] num;
	} ch_t;

	typedef struct packed {
		logic [13:0] board_temp;
		logic [13:0] stator_temp;
		ch_t         board;
		ch_t         stator;
	} mid_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} q_ctl_t;

endpackage

// File: rtl/ntd_front.sv
// ----------------------------------------------------------------------------
// ntd_front
// Table interpolation pipeline and derating class for both thermistors.
// ----------------------------------------------------------------------------
module ntd_front import ntd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] board_mv,
	input  logic [11:0] stator_mv,
	input  cfg_t        cfg,
	input  logic        mid_full,
	output logic        mid_push,
	output mid_t        mid_data
);

	typedef struct packed {
		logic [SEG_W-1:0] sel;
		logic [13:0]      base;
		logic [20:0]      x;
	} seg_t;

	function automatic seg_t seg_calc(input logic [11:0] mv);
		seg_t        s;
		logic [11:0] diff;
		s.sel = '0;
		for (int k = SEGS - 1; k >= 0; k--) begin
			if (mv >= NTC_MV[k + 1]) s.sel = SEG_W'(k);
		end
		diff = NTC_MV[s.sel] - mv;
		s.base = NTC_CENTI[s.sel];
		s.x = 21'(diff[9:0]) * SEG_SPAN;
		if (mv >= NTC_MV[0]) begin
			s.base = NTC_CENTI[0];
			s.x = '0;
		end else if (mv <= NTC_MV[TABLE_POINTS - 1]) begin
			s.base = NTC_CENTI[TABLE_POINTS - 1];
			s.x = '0;
		end
		return s;
	endfunction

	function automatic ch_t classify(input logic [13:0] t, input logic [14:0] f,
			input logic [14:0] m);
		ch_t         c;
		logic [15:0] start;
		start = {1'b0, f} - {1'b0, m};
		c.num = f - {1'b0, t};
		if ($signed({2'b00, t}) <= $signed(start)) begin
			c.cls = CLS_ONE;
		end else if ({1'b0, t} >= f || m == '0) begin
			c.cls = CLS_ZERO;
		end else begin
			c.cls = CLS_DIV;
		end
		return c;
	endfunction

	logic             adv;
	logic             v_s1, v_s2, v_s3;
	seg_t             seg_in [2];
	logic [SEG_W-1:0] sel_s1 [2], sel_s2 [2];
	logic [13:0]      base_s1 [2], base_s2 [2];
	logic [20:0]      x_s1 [2], x_s2 [2];
	logic [11:0]      q0_s2 [2];
	logic [13:0]      temp_s3 [2];
	logic [45:0]      prod [2];
	logic [21:0]      qd [2];
	logic [21:0]      rem [2];
	logic             inc [2];

	assign adv = !(v_s3 && mid_full);
	assign full = !adv;

	always_comb begin
		seg_in[0] = seg_calc(board_mv);
		seg_in[1] = seg_calc(stator_mv);
		for (int i = 0; i < 2; i++) begin
			prod[i] = 46'(x_s1[i]) * 46'(SEG_RECIP[sel_s1[i]]);
			qd[i] = 22'(q0_s2[i]) * 22'(SEG_DIV[sel_s2[i]]);
			rem[i] = 22'(x_s2[i]) - qd[i];
			inc[i] = rem[i] >= 22'(SEG_DIV[sel_s2[i]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 2; i++) begin
				sel_s1[i] <= seg_in[i].sel;
				base_s1[i] <= seg_in[i].base;
				x_s1[i] <= seg_in[i].x;
				sel_s2[i] <= sel_s1[i];
				base_s2[i] <= base_s1[i];
				x_s2[i] <= x_s1[i];
				q0_s2[i] <= prod[i][43:32];
				temp_s3[i] <= base_s2[i] + 14'(q0_s2[i]) + 14'(inc[i]);
			end
		end
	end

	assign mid_push = v_s3 && !mid_full;
	assign mid_data.board_temp = temp_s3[0];
	assign mid_data.stator_temp = temp_s3[1];
	assign mid_data.board = classify(temp_s3[0], cfg.board_fault, cfg.margin);
	assign mid_data.stator = classify(temp_s3[1], cfg.stator_fault, cfg.margin);

endmodule

// File: rtl/ntd_mid_fifo.sv
// ----------------------------------------------------------------------------
// ntd_mid_fifo
// Two-entry queue between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module ntd_mid_fifo import ntd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  mid_t   wdata,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output mid_t   rdata
);

	mid_t        mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

// File: rtl/ntd_back.sv
// ----------------------------------------------------------------------------
// ntd_back
// Radix-16 ramp dividers, scale minimum and the two-entry result queue.
// ----------------------------------------------------------------------------
module ntd_back import ntd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        mid_empty,
	input  mid_t        mid_data,
	output logic        mid_pop,
	input  logic        pop,
	output logic        empty,
	output logic [13:0] board_temp,
	output logic [13:0] stator_temp,
	output logic [15:0] current_scale,
	output logic        over_temp_fault
);

	typedef struct packed {
		logic [14:0] r;
		logic [15:0] q;
	} div_t;

	typedef struct packed {
		logic [13:0] board_temp;
		logic [13:0] stator_temp;
		logic [15:0] scale;
		logic        fault;
	} out_t;

	function automatic div_t div4(input div_t d, input logic [14:0] m);
		div_t        o;
		logic [15:0] t;
		o = d;
		for (int i = 0; i < 4; i++) begin
			t = {o.r, 1'b0};
			if (t >= {1'b0, m}) begin
				o.r = 15'(t - {1'b0, m});
				o.q = {o.q[14:0], 1'b1};
			end else begin
				o.r = t[14:0];
				o.q = {o.q[14:0], 1'b0};
			end
		end
		return o;
	endfunction

	function automatic logic [15:0] scale_of(input cls_t c, input logic [15:0] q);
		logic [15:0] s;
		case (c)
			CLS_ONE: s = SCALE_ONE;
			CLS_DIV: s = {1'b0, q[15:1]};
			default: s = '0;
		endcase
		return s;
	endfunction

	bk_state_t   state_q, state_d;
	logic [1:0]  cnt_q;
	div_t        div_q [2];
	div_t        div_nx [2];
	div_t        fin [2];
	cls_t        cls_q [2];
	logic [13:0] temp_q [2];
	logic        load, step, opush;
	logic [15:0] sc [2];
	out_t        res;
	out_t        oq_q [2];
	logic        owr_q, ord_q;
	logic [1:0]  ocnt_q;
	logic        ospace, opop;

	assign ospace = ocnt_q != 2'd2;
	assign opop = pop && !empty;
	assign empty = ocnt_q == 2'd0;
	assign mid_pop = load;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			div_nx[i] = div4(div_q[i], cfg.margin);
			fin[i] = (state_q == BK_DONE) ? div_q[i] : div_nx[i];
			sc[i] = scale_of(cls_q[i], fin[i].q);
		end
		res.board_temp = temp_q[0];
		res.stator_temp = temp_q[1];
		res.scale = (sc[1] < sc[0]) ? sc[1] : sc[0];
		res.fault = res.scale == '0;
	end

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		step = 1'b0;
		opush = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!mid_empty) begin
					load = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				step = 1'b1;
				if (cnt_q == 2'd3) begin
					if (ospace) begin
						opush = 1'b1;
						load = !mid_empty;
						state_d = mid_empty ? BK_IDLE : BK_RUN;
					end else begin
						state_d = BK_DONE;
					end
				end
			end
			BK_DONE: begin
				if (ospace) begin
					opush = 1'b1;
					load = !mid_empty;
					state_d = mid_empty ? BK_IDLE : BK_RUN;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
			owr_q <= 1'b0;
			ord_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) cnt_q <= '0;
			else if (step) cnt_q <= cnt_q + 2'd1;
			if (opush) owr_q <= !owr_q;
			if (opop) ord_q <= !ord_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			div_q[0] <= '{r: mid_data.board.num, q: '0};
			div_q[1] <= '{r: mid_data.stator.num, q: '0};
			cls_q[0] <= mid_data.board.cls;
			cls_q[1] <= mid_data.stator.cls;
			temp_q[0] <= mid_data.board_temp;
			temp_q[1] <= mid_data.stator_temp;
		end else if (step) begin
			div_q[0] <= div_nx[0];
			div_q[1] <= div_nx[1];
		end
		if (opush) oq_q[owr_q] <= res;
	end

	assign board_temp = oq_q[ord_q].board_temp;
	assign stator_temp = oq_q[ord_q].stator_temp;
	assign current_scale = oq_q[ord_q].scale;
	assign over_temp_fault = oq_q[ord_q].fault;

endmodule

// File: rtl/ntc_thermal_current_derate_top.sv
// ----------------------------------------------------------------------------
// ntc_thermal_current_derate_top
// NTC thermistor to temperature conversion with thermal current derating.
// ----------------------------------------------------------------------------
// The input side is a queue: a beat of board_mv and stator_mv is taken when
// push is high and full is low. The result side is a queue as well: the
// oldest result sits on the result ports while empty is low and is taken
// when pop is high. Configuration beats go in on cfg_valid and cfg_ready;
// cfg_ready is always high and an unknown index is ignored. The user must
// write registers only while the block holds no work; the block itself does
// not enforce this. A three-stage pipeline turns each voltage into a
// temperature and sorts the derating case. A two-entry queue feeds the back
// end, whose two radix-16 dividers work on one item at a time and take the
// next item from the queue as they hand a result to the result queue.
// When pop stays low, the result queue fills, then the middle queue, then
// full rises; nothing is lost. Reset empties every queue and loads the
// register reset values.
// ----------------------------------------------------------------------------
module ntc_thermal_current_derate_top import ntd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] board_mv,
	input  logic [11:0] stator_mv,
	output logic        empty,
	input  logic        pop,
	output logic [13:0] board_temp,
	output logic [13:0] stator_temp,
	output logic [15:0] current_scale,
	output logic        over_temp_fault,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	cfg_t   cfg_q;
	q_ctl_t mid;
	mid_t   mid_wdata, mid_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_fault <= 15'd12000;
			cfg_q.stator_fault <= 15'd15000;
			cfg_q.margin <= 15'd2500;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BOARD_FAULT: cfg_q.board_fault <= cfg_data;
				CFG_STATOR_FAULT: cfg_q.stator_fault <= cfg_data;
				CFG_MARGIN: cfg_q.margin <= cfg_data;
				default: ;
			endcase
		end
	end

	ntd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.board_mv(board_mv),
		.stator_mv(stator_mv),
		.cfg(cfg_q),
		.mid_full(mid.full),
		.mid_push(mid.push),
		.mid_data(mid_wdata)
	);

	ntd_mid_fifo u_mid (
		.clk(clk),
		.arst_n(arst_n),
		.push(mid.push),
		.wdata(mid_wdata),
		.pop(mid.pop),
		.full(mid.full),
		.empty(mid.empty),
		.rdata(mid_rdata)
	);

	ntd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.mid_empty(mid.empty),
		.mid_data(mid_rdata),
		.mid_pop(mid.pop),
		.pop(pop),
		.empty(empty),
		.board_temp(board_temp),
		.stator_temp(stator_temp),
		.current_scale(current_scale),
		.over_temp_fault(over_temp_fault)
	);

	a_fault_matches: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (over_temp_fault == (current_scale == 16'd0)))
		else $error("fault flag disagrees with scale");

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (current_scale <= SCALE_ONE))
		else $error("scale above full current");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (board_temp <= 14'd15000 && stator_temp <= 14'd15000))
		else $error("temperature out of table range");

	a_mid_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mid.push && mid.full && !mid.pop))
		else $error("middle queue overflow");

	a_mid_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mid.pop && mid.empty))
		else $error("middle queue underflow");

endmodule
